// ===== hdl/sed_pkg.sv =====
// Package for the STX/ETX response deframer: byte codes, event kinds,
// reply codes and frame lengths. No dependencies.
package sed_pkg;

  // Serial control bytes.
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ENQ = 8'h05;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_DLE = 8'h10;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_CAN = 8'h18;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_C   = 8'h43;

  // Command bytes with a fixed frame length.
  localparam logic [7:0] CMD_A = 8'h41;
  localparam logic [7:0] CMD_L = 8'h4c;
  localparam logic [7:0] CMD_P = 8'h50;
  localparam logic [7:0] CMD_V = 8'h56;

  // Frame lengths, the command byte included.
  localparam int unsigned LEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_A   = 7'd17;
  localparam logic [LEN_W-1:0] LEN_L   = 7'd100;
  localparam logic [LEN_W-1:0] LEN_P   = 7'd2;
  localparam logic [LEN_W-1:0] LEN_V   = 7'd14;
  localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;

  typedef enum logic [3:0] {
    EV_EOT   = 4'd0,
    EV_ENQ   = 4'd1,
    EV_ACK   = 4'd2,
    EV_DLE   = 4'd3,
    EV_NAK   = 4'd4,
    EV_CAN   = 4'd5,
    EV_CPU   = 4'd6,
    EV_CMD   = 4'd7,
    EV_DATA  = 4'd8,
    EV_GOOD  = 4'd9,
    EV_BAD   = 4'd10,
    EV_ABORT = 4'd11,
    EV_DUMP  = 4'd12,
    EV_DEND  = 4'd13
  } event_kind_e;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_NAK  = 2'd2
  } reply_e;

endpackage

// ===== hdl/sed_if.sv =====
// Stream interfaces of the STX/ETX response deframer: received bytes in,
// deframed events out. Depends on nothing.
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_has_colon;

  modport source (output valid, output rx_byte, output chunk_has_colon, input ready);
  modport sink   (input valid, input rx_byte, input chunk_has_colon, output ready);
endinterface

interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_kind;
  logic [7:0] event_byte;
  logic [1:0] reply_request;

  modport source (output valid, output event_kind, output event_byte,
                  output reply_request, input ready);
  modport sink   (input valid, input event_kind, input event_byte,
                  input reply_request, output ready);
endinterface

// ===== hdl/stx_etx_response_deframer_top.sv =====
// Top level of the STX/ETX response deframer: input register, parser state
// machine and result register. Depends on sed_pkg and the interfaces in sed_if.sv.
//
// The deframer takes one received byte per cycle and gives at most one event
// per byte, registered first in the input register and then in the result
// register. Throughput is one byte per clock, set by the parser update (an
// 8-bit adder, a 7-bit compare and byte decoders); it drops only while a
// result waits on a stalled output.
// Bytes that cause no event (STX, ETX, an extra 'C') just update the state.
module stx_etx_response_deframer_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  sed_in_if.sink   rx_i,
  sed_out_if.source ev_o
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_CMD    = 3'd1;
  localparam logic [2:0] MODE_DATA   = 3'd2;
  localparam logic [2:0] MODE_SUM    = 3'd3;
  localparam logic [2:0] MODE_DSTART = 3'd4;
  localparam logic [2:0] MODE_DDATA  = 3'd5;

  // Input register.
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_colon_q;

  // Parser state.
  logic [2:0]              mode_q, mode_d;
  logic [sed_pkg::LEN_W-1:0] exp_len_q, exp_len_d;
  logic                    unk_q, unk_d;
  logic [sed_pkg::LEN_W-1:0] cnt_q, cnt_d;
  logic [7:0]              sum_q, sum_d;
  logic [1:0]              crun_q, crun_d;
  logic                    boot_q, boot_d;

  // Result register.
  logic       out_v_q;
  logic [3:0] out_kind_q;
  logic [7:0] out_byte_q;
  logic [1:0] out_reply_q;

  logic                 out_free;
  logic                 step_en;
  logic                 res_v;
  sed_pkg::event_kind_e res_kind;
  logic [7:0]           res_byte;
  sed_pkg::reply_e      res_reply;

  assign out_free   = !out_v_q || ev_o.ready;
  assign step_en    = in_v_q && out_free;
  assign rx_i.ready = !in_v_q || out_free;

  always_comb begin
    mode_d    = mode_q;
    exp_len_d = exp_len_q;
    unk_d     = unk_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    crun_d    = crun_q;
    boot_d    = boot_q;
    res_v     = 1'b0;
    res_kind  = sed_pkg::EV_EOT;
    res_byte  = 8'd0;
    res_reply = sed_pkg::REPLY_NONE;

    case (mode_q)
      MODE_CMD: begin
        mode_d   = MODE_DATA;
        sum_d    = in_byte_q;
        cnt_d    = {{(sed_pkg::LEN_W-1){1'b0}}, 1'b1};
        unk_d    = 1'b0;
        res_v    = 1'b1;
        res_kind = sed_pkg::EV_CMD;
        res_byte = in_byte_q;
        case (in_byte_q)
          sed_pkg::CMD_A: exp_len_d = sed_pkg::LEN_A;
          sed_pkg::CMD_L: exp_len_d = sed_pkg::LEN_L;
          sed_pkg::CMD_P: exp_len_d = sed_pkg::LEN_P;
          sed_pkg::CMD_V: exp_len_d = sed_pkg::LEN_V;
          default: begin
            exp_len_d = '0;
            unk_d     = 1'b1;
          end
        endcase
      end
      MODE_DATA: begin
        sum_d = sum_q + in_byte_q;
        if (unk_q && in_byte_q == sed_pkg::BYTE_ETX) begin
          mode_d = MODE_SUM;
        end else if (!unk_q && cnt_q == exp_len_q) begin
          // Full length collected: only ETX may follow.
          if (in_byte_q == sed_pkg::BYTE_ETX) begin
            mode_d = MODE_SUM;
          end else begin
            mode_d   = MODE_IDLE;
            res_v    = 1'b1;
            res_kind = sed_pkg::EV_ABORT;
          end
        end else begin
          if (cnt_q != sed_pkg::LEN_MAX) begin
            cnt_d = cnt_q + 1'b1;
          end
          res_v    = 1'b1;
          res_kind = sed_pkg::EV_DATA;
          res_byte = in_byte_q;
        end
      end
      MODE_SUM: begin
        mode_d = MODE_IDLE;
        res_v  = 1'b1;
        if (sum_q == in_byte_q) begin
          res_kind  = sed_pkg::EV_GOOD;
          res_reply = (boot_q && unk_q) ? sed_pkg::REPLY_ACK : sed_pkg::REPLY_NONE;
        end else begin
          res_kind  = sed_pkg::EV_BAD;
          res_reply = boot_q ? sed_pkg::REPLY_NAK : sed_pkg::REPLY_NONE;
        end
      end
      MODE_DSTART: begin
        // The first dump byte is reported as data even if it is a line feed.
        mode_d   = MODE_DDATA;
        res_v    = 1'b1;
        res_kind = sed_pkg::EV_DUMP;
        res_byte = in_byte_q;
      end
      MODE_DDATA: begin
        res_v    = 1'b1;
        res_byte = in_byte_q;
        if (in_byte_q == sed_pkg::BYTE_LF) begin
          mode_d   = MODE_IDLE;
          res_kind = sed_pkg::EV_DEND;
        end else begin
          res_kind = sed_pkg::EV_DUMP;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        crun_d = 2'd0;
        case (in_byte_q)
          sed_pkg::BYTE_STX: mode_d = MODE_CMD;
          sed_pkg::BYTE_EOT: begin
            res_v    = 1'b1;
            res_kind = sed_pkg::EV_EOT;
          end
          sed_pkg::BYTE_ENQ: begin
            res_v    = 1'b1;
            res_kind = sed_pkg::EV_ENQ;
          end
          sed_pkg::BYTE_ACK: begin
            res_v    = 1'b1;
            res_kind = sed_pkg::EV_ACK;
          end
          sed_pkg::BYTE_DLE: begin
            res_v    = 1'b1;
            res_kind = sed_pkg::EV_DLE;
          end
          sed_pkg::BYTE_NAK: begin
            res_v    = 1'b1;
            res_kind = sed_pkg::EV_NAK;
          end
          sed_pkg::BYTE_CAN: begin
            res_v    = 1'b1;
            res_kind = sed_pkg::EV_CAN;
          end
          sed_pkg::BYTE_C: begin
            // Once bootloader mode is latched, a 'C' changes nothing.
            crun_d = crun_q;
            if (!boot_q) begin
              crun_d = crun_q + 2'd1;
              if (crun_q == 2'd2) begin
                boot_d   = 1'b1;
                res_v    = 1'b1;
                res_kind = sed_pkg::EV_CPU;
              end
            end
          end
          default: begin
            if (in_colon_q) begin
              mode_d   = MODE_DSTART;
              res_v    = 1'b1;
              res_kind = sed_pkg::EV_DUMP;
              res_byte = in_byte_q;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      mode_q    <= MODE_IDLE;
      exp_len_q <= '0;
      unk_q     <= 1'b0;
      cnt_q     <= '0;
      sum_q     <= 8'd0;
      crun_q    <= 2'd0;
      boot_q    <= 1'b0;
    end else begin
      if (rx_i.ready) begin
        in_v_q <= rx_i.valid;
      end
      if (out_free) begin
        out_v_q <= step_en && res_v;
      end
      if (step_en) begin
        mode_q    <= mode_d;
        exp_len_q <= exp_len_d;
        unk_q     <= unk_d;
        cnt_q     <= cnt_d;
        sum_q     <= sum_d;
        crun_q    <= crun_d;
        boot_q    <= boot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q  <= rx_i.rx_byte;
      in_colon_q <= rx_i.chunk_has_colon;
    end
    if (step_en && res_v) begin
      out_kind_q  <= res_kind;
      out_byte_q  <= res_byte;
      out_reply_q <= res_reply;
    end
  end

  assign ev_o.valid         = out_v_q;
  assign ev_o.event_kind    = out_kind_q;
  assign ev_o.event_byte    = out_byte_q;
  assign ev_o.reply_request = out_reply_q;

  // Bootloader mode is sticky until reset.
  a_boot_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    boot_q |=> boot_q)
    else $error("bootloader mode cleared without reset");

  // A reply is only ever requested with a checksum verdict.
  a_reply_on_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_o.valid && ev_o.reply_request != sed_pkg::REPLY_NONE) |->
      (ev_o.event_kind == sed_pkg::EV_GOOD || ev_o.event_kind == sed_pkg::EV_BAD))
    else $error("reply request outside a good or bad event");

  // An ACK reply belongs to a frame with an unknown command in bootloader mode.
  a_ack_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_o.valid && ev_o.reply_request == sed_pkg::REPLY_ACK) |-> (boot_q && unk_q))
    else $error("ACK reply without bootloader mode and unknown command");

endmodule

// ===== verif/sed_checker.sv =====
// Checker for the STX/ETX response deframer: watches both streams, predicts the
// events of each received byte and compares them in order. Depends on sed_pkg.
module sed_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  input  logic              rx_ready_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              rx_colon_i,
  input  logic              ev_valid_i,
  input  logic              ev_ready_i,
  input  logic [3:0]        ev_kind_i,
  input  logic [7:0]        ev_byte_i,
  input  logic [1:0]        ev_reply_i,
  input  logic              run_done_i,
  output int unsigned       pending_o,
  output int unsigned       errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PM_IDLE    = 3'd0,
    PM_CMD     = 3'd1,
    PM_PAYLOAD = 3'd2,
    PM_SUM     = 3'd3,
    PM_DSTART  = 3'd4,
    PM_DDATA   = 3'd5
  } parse_mode_e;

  typedef struct packed {
    sed_pkg::event_kind_e kind;
    logic [7:0]           data;
    sed_pkg::reply_e      reply;
  } deframed_ev_t;

  // Mirror of the parser state.
  parse_mode_e               mode;
  logic [sed_pkg::LEN_W-1:0] frame_len;
  logic                      len_unknown;
  logic [sed_pkg::LEN_W-1:0] frame_count;
  logic [7:0]                frame_sum;
  logic [1:0]                c_run;
  logic                      boot_mode;

  deframed_ev_t expected_q[$];
  int unsigned  err_count = 0;
  bit           leftover_seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] sed_checker: %s", $time, msg);
    err_count++;
  endtask

  // Advances the mirrored parser by one byte; returns 1 when the byte gives an event.
  function automatic bit deframe_byte(input logic [7:0] b, input logic colon,
                                      output deframed_ev_t ev);
    ev = '{kind: sed_pkg::EV_EOT, data: 8'h00, reply: sed_pkg::REPLY_NONE};
    case (mode)
      PM_CMD: begin
        mode        = PM_PAYLOAD;
        frame_sum   = b;
        frame_count = 7'd1;
        len_unknown = 1'b0;
        case (b)
          sed_pkg::CMD_A: frame_len = sed_pkg::LEN_A;
          sed_pkg::CMD_L: frame_len = sed_pkg::LEN_L;
          sed_pkg::CMD_P: frame_len = sed_pkg::LEN_P;
          sed_pkg::CMD_V: frame_len = sed_pkg::LEN_V;
          default: begin
            frame_len   = '0;
            len_unknown = 1'b1;
          end
        endcase
        ev.kind = sed_pkg::EV_CMD;
        ev.data = b;
        return 1'b1;
      end
      PM_PAYLOAD: begin
        frame_sum = frame_sum + b;
        if (len_unknown && b == sed_pkg::BYTE_ETX) begin
          mode = PM_SUM;
          return 1'b0;
        end
        // A known frame must close with ETX right after its full length.
        if (!len_unknown && frame_count == frame_len) begin
          if (b == sed_pkg::BYTE_ETX) begin
            mode = PM_SUM;
            return 1'b0;
          end
          mode    = PM_IDLE;
          ev.kind = sed_pkg::EV_ABORT;
          return 1'b1;
        end
        if (frame_count < sed_pkg::LEN_MAX) frame_count = frame_count + 7'd1;
        ev.kind = sed_pkg::EV_DATA;
        ev.data = b;
        return 1'b1;
      end
      PM_SUM: begin
        mode = PM_IDLE;
        if (frame_sum == b) begin
          ev.kind  = sed_pkg::EV_GOOD;
          ev.reply = (boot_mode && len_unknown) ? sed_pkg::REPLY_ACK : sed_pkg::REPLY_NONE;
        end else begin
          ev.kind  = sed_pkg::EV_BAD;
          ev.reply = boot_mode ? sed_pkg::REPLY_NAK : sed_pkg::REPLY_NONE;
        end
        return 1'b1;
      end
      PM_DSTART: begin
        mode    = PM_DDATA;
        ev.kind = sed_pkg::EV_DUMP;
        ev.data = b;
        return 1'b1;
      end
      PM_DDATA: begin
        ev.data = b;
        if (b == sed_pkg::BYTE_LF) begin
          mode    = PM_IDLE;
          ev.kind = sed_pkg::EV_DEND;
        end else begin
          ev.kind = sed_pkg::EV_DUMP;
        end
        return 1'b1;
      end
      default: begin
        mode = PM_IDLE;
        if (b != sed_pkg::BYTE_C) c_run = 2'd0;
        case (b)
          sed_pkg::BYTE_STX: begin
            mode = PM_CMD;
            return 1'b0;
          end
          sed_pkg::BYTE_EOT: ev.kind = sed_pkg::EV_EOT;
          sed_pkg::BYTE_ENQ: ev.kind = sed_pkg::EV_ENQ;
          sed_pkg::BYTE_ACK: ev.kind = sed_pkg::EV_ACK;
          sed_pkg::BYTE_DLE: ev.kind = sed_pkg::EV_DLE;
          sed_pkg::BYTE_NAK: ev.kind = sed_pkg::EV_NAK;
          sed_pkg::BYTE_CAN: ev.kind = sed_pkg::EV_CAN;
          sed_pkg::BYTE_C: begin
            // Once bootloader mode is latched a 'C' changes nothing.
            if (!boot_mode) begin
              c_run = c_run + 2'd1;
              if (c_run == 2'd3) begin
                boot_mode = 1'b1;
                ev.kind   = sed_pkg::EV_CPU;
                return 1'b1;
              end
            end
            return 1'b0;
          end
          default: begin
            if (!colon) return 1'b0;
            mode    = PM_DSTART;
            ev.kind = sed_pkg::EV_DUMP;
            ev.data = b;
          end
        endcase
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deframed_ev_t got;
    deframed_ev_t want;
    deframed_ev_t pred;
    if (!rst_ni) begin
      mode          = PM_IDLE;
      frame_len     = '0;
      len_unknown   = 1'b0;
      frame_count   = '0;
      frame_sum     = '0;
      c_run         = '0;
      boot_mode     = 1'b0;
      leftover_seen = 1'b0;
      expected_q.delete();
      pending_o <= 0;
      errors_o  <= err_count;
    end else begin
      if (ev_valid_i && ev_ready_i) begin
        got = '{kind: sed_pkg::event_kind_e'(ev_kind_i), data: ev_byte_i,
                reply: sed_pkg::reply_e'(ev_reply_i)};
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("event kind %0d byte %02h with nothing expected",
                                    ev_kind_i, ev_byte_i));
        end else begin
          want = expected_q.pop_front();
          if (got.kind != want.kind)
            report_mismatch($sformatf("event_kind got %0d want %0d (%s)",
                                      ev_kind_i, want.kind, want.kind.name()));
          if (got.data != want.data)
            report_mismatch($sformatf("event_byte got %02h want %02h on %s",
                                      got.data, want.data, want.kind.name()));
          if (got.reply != want.reply)
            report_mismatch($sformatf("reply_request got %0d want %0d on %s",
                                      ev_reply_i, want.reply, want.kind.name()));
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        if (deframe_byte(rx_byte_i, rx_colon_i, pred)) expected_q.push_back(pred);
      end
      if (run_done_i && !leftover_seen && expected_q.size() != 0) begin
        leftover_seen = 1'b1;
        report_mismatch($sformatf("%0d events never arrived", expected_q.size()));
      end
      pending_o <= expected_q.size();
      errors_o  <= err_count;
    end
  end

endmodule

// ===== verif/stx_etx_response_deframer_top_tb.sv =====
// Top of the deframer testbench: clock, reset, byte stimulus with random gaps,
// output back-pressure, watchdog and verdict. Depends on sed_pkg, sed_if.sv and sed_checker.
module stx_etx_response_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Two-stage pipeline plus margin.
  localparam int unsigned DRAIN_CYCLES = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        gaps_on;
  logic        run_done;
  int unsigned pending;
  int unsigned errors;
  int unsigned items_sent;

  logic [7:0] ctrl_bytes [6] = '{sed_pkg::BYTE_EOT, sed_pkg::BYTE_ENQ, sed_pkg::BYTE_ACK,
                                 sed_pkg::BYTE_DLE, sed_pkg::BYTE_NAK, sed_pkg::BYTE_CAN};

  sed_in_if  rx_if ();
  sed_out_if ev_if ();

  stx_etx_response_deframer_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .ev_o   (ev_if)
  );

  sed_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_if.valid),
    .rx_ready_i (rx_if.ready),
    .rx_byte_i  (rx_if.rx_byte),
    .rx_colon_i (rx_if.chunk_has_colon),
    .ev_valid_i (ev_if.valid),
    .ev_ready_i (ev_if.ready),
    .ev_kind_i  (ev_if.event_kind),
    .ev_byte_i  (ev_if.event_byte),
    .ev_reply_i (ev_if.reply_request),
    .run_done_i (run_done),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Output back-pressure: random stall bursts while gaps are enabled.
  initial begin
    int unsigned burst;
    burst       = 0;
    ev_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        ev_if.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        ev_if.ready <= (burst == 0);
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 16);
        ev_if.ready <= 1'b0;
      end else begin
        ev_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (rx_if.valid && rx_if.ready) || (ev_if.valid && ev_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("stx_etx_response_deframer_top_tb: done, errors");
    $finish;
  end

  // One byte transfer, optionally preceded by an idle burst on the input.
  task automatic push_byte(input logic [7:0] b, input logic colon);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid           <= 1'b1;
    rx_if.rx_byte         <= b;
    rx_if.chunk_has_colon <= colon;
    do @(posedge clk_i); while (!rx_if.ready);
    items_sent++;
  endtask

  // STX, command, payload, ETX and checksum; a bad sum is offset by a nonzero amount.
  task automatic send_frame(input logic [7:0] cmd, input int unsigned n_payload,
                            input bit sum_ok);
    logic [7:0] sum;
    logic [7:0] b;
    bit         unknown;
    unknown = !(cmd inside {sed_pkg::CMD_A, sed_pkg::CMD_L, sed_pkg::CMD_P, sed_pkg::CMD_V});
    sum     = cmd;
    push_byte(sed_pkg::BYTE_STX, 1'($urandom_range(0, 1)));
    push_byte(cmd, 1'($urandom_range(0, 1)));
    for (int i = 0; i < n_payload; i++) begin
      b = 8'($urandom_range(0, 255));
      if (unknown && b == sed_pkg::BYTE_ETX) b = 8'h83;
      sum = sum + b;
      push_byte(b, 1'($urandom_range(0, 1)));
    end
    sum = sum + sed_pkg::BYTE_ETX;
    push_byte(sed_pkg::BYTE_ETX, 1'($urandom_range(0, 1)));
    if (!sum_ok) sum = sum + 8'($urandom_range(1, 255));
    push_byte(sum, 1'($urandom_range(0, 1)));
  endtask

  task automatic random_sequence(input bit allow_c);
    int unsigned pick;
    int          n;
    int          nominal;
    logic [7:0]  b;
    logic [7:0]  cmd;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      b = 8'($urandom_range(0, 255));
      if (!allow_c && b == sed_pkg::BYTE_C) b = 8'h44;
      push_byte(b, 1'($urandom_range(0, 1)));
    end else if (pick < 20) begin
      push_byte(ctrl_bytes[$urandom_range(0, 5)], 1'($urandom_range(0, 1)));
    end else if (pick < 24) begin
      // A short run of 'C' broken by a control byte.
      repeat ($urandom_range(1, allow_c ? 4 : 2))
        push_byte(sed_pkg::BYTE_C, 1'($urandom_range(0, 1)));
      push_byte(ctrl_bytes[$urandom_range(0, 5)], 1'($urandom_range(0, 1)));
    end else if (pick < 34) begin
      b = 8'($urandom_range(8'h20, 8'h7e));
      if (b == sed_pkg::BYTE_C) b = 8'h3a;
      push_byte(b, 1'b1);
      repeat ($urandom_range(0, 12)) begin
        b = 8'($urandom_range(0, 255));
        if (b == sed_pkg::BYTE_LF) b = 8'h3a;
        push_byte(b, 1'($urandom_range(0, 1)));
      end
      push_byte(sed_pkg::BYTE_LF, 1'($urandom_range(0, 1)));
    end else if (pick < 97) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        cmd = sed_pkg::CMD_P; nominal = int'(sed_pkg::LEN_P) - 1;
      end else if (pick < 55) begin
        cmd = sed_pkg::CMD_V; nominal = int'(sed_pkg::LEN_V) - 1;
      end else if (pick < 72) begin
        cmd = sed_pkg::CMD_A; nominal = int'(sed_pkg::LEN_A) - 1;
      end else if (pick < 77) begin
        cmd = sed_pkg::CMD_L; nominal = int'(sed_pkg::LEN_L) - 1;
      end else begin
        do cmd = 8'($urandom_range(0, 255));
        while (cmd inside {sed_pkg::CMD_A, sed_pkg::CMD_L, sed_pkg::CMD_P, sed_pkg::CMD_V});
        nominal = int'($urandom_range(0, 20));
      end
      n = nominal;
      // Some known frames get a wrong length: short ones swallow what follows,
      // long ones abort.
      if (pick < 77 && $urandom_range(0, 99) < 15) n = nominal + int'($urandom_range(0, 5)) - 2;
      if (n < 0) n = 0;
      send_frame(cmd, n, $urandom_range(0, 3) != 0);
    end else begin
      // Long unknown frame that runs the byte count into saturation.
      do cmd = 8'($urandom_range(0, 255));
      while (cmd inside {sed_pkg::CMD_A, sed_pkg::CMD_L, sed_pkg::CMD_P, sed_pkg::CMD_V});
      send_frame(cmd, $urandom_range(126, 140), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned wait_cycles;
    rst_ni                = 1'b0;
    rx_if.valid           = 1'b0;
    rx_if.rx_byte         = '0;
    rx_if.chunk_has_colon = 1'b0;
    gaps_on               = 1'b1;
    run_done              = 1'b0;
    items_sent            = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: control bytes, dump lines, a C run cut by STX, frame endings.
    for (int i = 0; i < 6; i++) push_byte(ctrl_bytes[i], 1'(i));
    push_byte(8'h00, 1'b0);             // plain byte without a colon: no event
    push_byte(8'hff, 1'b1);             // starts a dump line
    push_byte(sed_pkg::BYTE_LF, 1'b0);  // first byte after the start is dumped even if LF
    push_byte(sed_pkg::BYTE_C, 1'b1);
    push_byte(sed_pkg::BYTE_LF, 1'b1);  // ends the line
    push_byte(sed_pkg::BYTE_C, 1'b0);
    push_byte(sed_pkg::BYTE_C, 1'b0);
    send_frame(sed_pkg::CMD_P, sed_pkg::LEN_P - 1, 1'b1);
    send_frame(8'h00, 0, 1'b0);
    push_byte(sed_pkg::BYTE_STX, 1'b0); // P frame overrun: aborted on the extra byte
    push_byte(sed_pkg::CMD_P, 1'b1);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b1);

    // Random traffic before bootloader mode is latched.
    while (items_sent < 500) random_sequence(1'b0);

    // Hold the input until the pipeline has drained.
    rx_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    // Latch bootloader mode, then frames that request ACK and NAK replies and one that requests none.
    repeat (4) push_byte(sed_pkg::BYTE_C, 1'b0);
    send_frame(8'h7e, 2, 1'b1);
    send_frame(sed_pkg::CMD_P, sed_pkg::LEN_P - 1, 1'b0);
    send_frame(sed_pkg::CMD_V, sed_pkg::LEN_V - 1, 1'b1);

    while (items_sent < 1100) begin
      if (items_sent >= 950) gaps_on <= 1'b0;
      random_sequence(1'b1);
    end

    rx_if.valid <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk_i);
      wait_cycles++;
    end while (pending != 0 && wait_cycles < STALL_LIMIT);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    run_done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (errors == 0) begin
      $display("stx_etx_response_deframer_top_tb: done, clean");
    end else begin
      $display("stx_etx_response_deframer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
